// ===== sv/dtw_pkg.sv =====
// ----------------------------------------------------------------------------
// dtw_pkg: shared definitions for the two-way ranging distance block
// Status codes, register indexes, reset values and the control word that
// travels with each transaction down the pipeline.
// ----------------------------------------------------------------------------
package dtw_pkg;

    localparam int TIME_BITS_DEF       = 32;
    localparam int SCALE_FRAC_BITS_DEF = 24;

    localparam int CM_W   = 32;
    localparam int TOL_W  = 10;
    localparam int DIST_W = 16;
    localparam int STAT_W = 2;

    localparam logic [CM_W-1:0]  CM_PER_TICK_RST = 32'd7871472;
    localparam logic [TOL_W-1:0] NEG_TOL_RST     = 10'd55;

    typedef enum logic [0:0] {
        REG_CM_PER_TICK = 1'b0,
        REG_NEG_TOL     = 1'b1
    } reg_idx_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK       = 2'd0,
        ST_MISSING  = 2'd1,
        ST_ZERO_DIV = 2'd2,
        ST_TOO_NEG  = 2'd3
    } status_t;

    typedef struct packed {
        logic    vld;
        logic    neg;
        status_t status;
    } ctrl_t;

endpackage

// ===== sv/dtw_front.sv =====
// ----------------------------------------------------------------------------
// dtw_front: intervals, cross products and signed difference
// Three register stages: intervals and checks, the two products, and the
// magnitude and sign of their difference.
// ----------------------------------------------------------------------------
module dtw_front #(
    parameter int TIME_BITS = dtw_pkg::TIME_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  logic                   in_vld,
    input  logic [TIME_BITS-1:0]   poll_tx_time,
    input  logic [TIME_BITS-1:0]   poll_rx_time,
    input  logic [TIME_BITS-1:0]   resp_tx_time,
    input  logic [TIME_BITS-1:0]   resp_rx_time,
    input  logic [TIME_BITS-1:0]   final_tx_time,
    input  logic [TIME_BITS-1:0]   final_rx_time,
    output dtw_pkg::ctrl_t         ctrl_out,
    output logic [2*TIME_BITS-1:0] mag_out,
    output logic [TIME_BITS+1:0]   den_out
);

    localparam int T = TIME_BITS;

    logic [T-1:0]   round1, round2, reply1, reply2;
    logic [T+1:0]   den;
    logic           any_zero;

    dtw_pkg::ctrl_t ctrl1_reg, ctrl2_reg, ctrl3_reg;
    dtw_pkg::ctrl_t ctrl1_next, ctrl3_next;
    logic [T-1:0]   round1_reg, round2_reg, reply1_reg, reply2_reg;
    logic [T+1:0]   den1_reg, den2_reg, den3_reg;
    logic [2*T-1:0] p1_reg, p2_reg, mag_reg;

    assign round1 = resp_rx_time - poll_tx_time;
    assign round2 = final_rx_time - resp_tx_time;
    assign reply1 = resp_tx_time - poll_rx_time;
    assign reply2 = final_tx_time - resp_rx_time;
    assign den    = {2'b00, round1} + {2'b00, round2} + {2'b00, reply1} + {2'b00, reply2};

    assign any_zero = (poll_tx_time == '0) || (poll_rx_time == '0) ||
                      (resp_tx_time == '0) || (resp_rx_time == '0) ||
                      (final_tx_time == '0) || (final_rx_time == '0);

    always_comb begin
        ctrl1_next.vld = in_vld;
        ctrl1_next.neg = 1'b0;
        if (any_zero) begin
            ctrl1_next.status = dtw_pkg::ST_MISSING;
        end else if (den == '0) begin
            ctrl1_next.status = dtw_pkg::ST_ZERO_DIV;
        end else begin
            ctrl1_next.status = dtw_pkg::ST_OK;
        end
    end

    always_comb begin
        ctrl3_next     = ctrl2_reg;
        ctrl3_next.neg = (p1_reg < p2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
            ctrl3_reg <= '0;
        end else if (en) begin
            ctrl1_reg <= ctrl1_next;
            ctrl2_reg <= ctrl1_reg;
            ctrl3_reg <= ctrl3_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            round1_reg <= round1;
            round2_reg <= round2;
            reply1_reg <= reply1;
            reply2_reg <= reply2;
            den1_reg   <= den;
            p1_reg     <= round1_reg * round2_reg;
            p2_reg     <= reply1_reg * reply2_reg;
            den2_reg   <= den1_reg;
            mag_reg    <= (p1_reg < p2_reg) ? (p2_reg - p1_reg) : (p1_reg - p2_reg);
            den3_reg   <= den2_reg;
        end
    end

    assign ctrl_out = ctrl3_reg;
    assign mag_out  = mag_reg;
    assign den_out  = den3_reg;

endmodule

// ===== sv/dtw_div_cell.sv =====
// ----------------------------------------------------------------------------
// dtw_div_cell: one step of a restoring divider
// Brings down one numerator bit, subtracts the divisor where it fits and
// shifts the quotient bit in behind the remaining numerator bits.
// ----------------------------------------------------------------------------
module dtw_div_cell #(
    parameter int TIME_BITS = dtw_pkg::TIME_BITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   en,
    input  dtw_pkg::ctrl_t         ctrl_in,
    input  logic [2*TIME_BITS-1:0] nq_in,
    input  logic [TIME_BITS+1:0]   rem_in,
    input  logic [TIME_BITS+1:0]   den_in,
    output dtw_pkg::ctrl_t         ctrl_out,
    output logic [2*TIME_BITS-1:0] nq_out,
    output logic [TIME_BITS+1:0]   rem_out,
    output logic [TIME_BITS+1:0]   den_out
);

    localparam int T = TIME_BITS;

    logic [T+2:0]   rem_sh, rem_sub;
    logic           fits;
    dtw_pkg::ctrl_t ctrl_reg;
    logic [2*T-1:0] nq_reg;
    logic [T+1:0]   rem_reg, den_reg;

    assign rem_sh  = {rem_in, nq_in[2*T-1]};
    assign rem_sub = rem_sh - {1'b0, den_in};
    assign fits    = (rem_sh >= {1'b0, den_in});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl_reg <= '0;
        end else if (en) begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nq_reg  <= {nq_in[2*T-2:0], fits};
            rem_reg <= fits ? rem_sub[T+1:0] : rem_sh[T+1:0];
            den_reg <= den_in;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign nq_out   = nq_reg;
    assign rem_out  = rem_reg;
    assign den_out  = den_reg;

endmodule

// ===== sv/dtw_scale.sv =====
// ----------------------------------------------------------------------------
// dtw_scale: conversion of the time of flight to centimetres
// Two half-width products of the quotient and the scale factor, then their
// sum; the final tolerance and saturation checks follow combinationally.
// ----------------------------------------------------------------------------
module dtw_scale #(
    parameter int TIME_BITS       = dtw_pkg::TIME_BITS_DEF,
    parameter int SCALE_FRAC_BITS = dtw_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  dtw_pkg::ctrl_t             ctrl_in,
    input  logic [2*TIME_BITS-1:0]     quot_in,
    input  logic [dtw_pkg::CM_W-1:0]   cm_per_tick,
    input  logic [dtw_pkg::TOL_W-1:0]  neg_tol,
    output logic                       res_vld,
    output dtw_pkg::status_t           res_status,
    output logic [dtw_pkg::DIST_W-1:0] res_dist
);

    localparam int T  = TIME_BITS;
    localparam int F  = SCALE_FRAC_BITS;
    localparam int PW = 2*T + dtw_pkg::CM_W;
    localparam int HW = T + dtw_pkg::CM_W;

    dtw_pkg::ctrl_t ctrl1_reg, ctrl2_reg;
    logic [HW-1:0]  plo_reg, phi_reg;
    logic [PW-1:0]  prod_reg;
    logic [PW-1:0]  lim;
    logic           too_neg, sat;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctrl1_reg <= '0;
            ctrl2_reg <= '0;
        end else if (en) begin
            ctrl1_reg <= ctrl_in;
            ctrl2_reg <= ctrl1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            plo_reg  <= quot_in[T-1:0] * cm_per_tick;
            phi_reg  <= quot_in[2*T-1:T] * cm_per_tick;
            prod_reg <= {{T{1'b0}}, plo_reg} + {phi_reg, {T{1'b0}}};
        end
    end

    assign lim     = {{(PW-dtw_pkg::TOL_W){1'b0}}, neg_tol} << F;
    assign too_neg = (prod_reg > lim);
    assign sat     = (prod_reg[PW-1:F+dtw_pkg::DIST_W] != '0);

    always_comb begin
        res_vld    = ctrl2_reg.vld;
        res_status = ctrl2_reg.status;
        res_dist   = '0;
        if (ctrl2_reg.status == dtw_pkg::ST_OK) begin
            if (ctrl2_reg.neg) begin
                if (too_neg) begin
                    res_status = dtw_pkg::ST_TOO_NEG;
                end
            end else if (sat) begin
                res_dist = '1;
            end else begin
                res_dist = prod_reg[F+dtw_pkg::DIST_W-1:F];
            end
        end
    end

endmodule

// ===== sv/ds_twr_distance.sv =====
// ----------------------------------------------------------------------------
// ds_twr_distance: distance from a double-sided two-way ranging exchange
//
//  channel | direction | transaction contents
//  s_      | in        | six timestamps of one exchange
//  m_      | out       | status and distance in centimetres
//  cfg_    | in        | register write: cm_per_tick, negative tolerance
//
// One transaction is accepted per cycle while s_tready is high; each result
// runs through the front, the divider's one-bit cells and the scale stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register reset values. A stalled output is held in the output register
// and one skid entry; the pipeline then halts until the skid entry drains.
// ----------------------------------------------------------------------------
module ds_twr_distance #(
    parameter int TIME_BITS       = dtw_pkg::TIME_BITS_DEF,
    parameter int SCALE_FRAC_BITS = dtw_pkg::SCALE_FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // poll_tx, poll_rx, resp_tx, resp_rx, final_tx, final_rx times, zero pad
    input  logic [((6*TIME_BITS+7)/8)*8-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status [1:0], distance_cm [17:2], zero pad
    output logic [23:0]                    m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [0:0]                     cfg_addr,
    input  logic [dtw_pkg::CM_W-1:0]       cfg_wdata
);

    localparam int T  = TIME_BITS;
    localparam int NC = 2*T;
    localparam int RW = dtw_pkg::STAT_W + dtw_pkg::DIST_W;

    logic [dtw_pkg::CM_W-1:0]  cm_reg;
    logic [dtw_pkg::TOL_W-1:0] tol_reg;
    logic                      en;

    dtw_pkg::ctrl_t ctrl_c [NC+1];
    logic [2*T-1:0] nq_c   [NC+1];
    logic [T+1:0]   rem_c  [NC+1];
    logic [T+1:0]   den_c  [NC+1];

    logic                       r_vld;
    dtw_pkg::status_t           r_status;
    logic [dtw_pkg::DIST_W-1:0] r_dist;
    logic [RW-1:0]              r_data;
    logic                       m_vld_reg, skid_vld_reg;
    logic [RW-1:0]              m_data_reg, skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cm_reg  <= dtw_pkg::CM_PER_TICK_RST;
            tol_reg <= dtw_pkg::NEG_TOL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                dtw_pkg::REG_CM_PER_TICK: cm_reg  <= cfg_wdata;
                dtw_pkg::REG_NEG_TOL:     tol_reg <= cfg_wdata[dtw_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    assign en       = !skid_vld_reg;
    assign s_tready = en;

    dtw_front #(.TIME_BITS(T)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .en            (en),
        .in_vld        (s_tvalid),
        .poll_tx_time  (s_tdata[T-1:0]),
        .poll_rx_time  (s_tdata[2*T-1:T]),
        .resp_tx_time  (s_tdata[3*T-1:2*T]),
        .resp_rx_time  (s_tdata[4*T-1:3*T]),
        .final_tx_time (s_tdata[5*T-1:4*T]),
        .final_rx_time (s_tdata[6*T-1:5*T]),
        .ctrl_out      (ctrl_c[0]),
        .mag_out       (nq_c[0]),
        .den_out       (den_c[0])
    );

    assign rem_c[0] = '0;

    for (genvar i = 0; i < NC; i++) begin : g_div
        dtw_div_cell #(.TIME_BITS(T)) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .ctrl_in  (ctrl_c[i]),
            .nq_in    (nq_c[i]),
            .rem_in   (rem_c[i]),
            .den_in   (den_c[i]),
            .ctrl_out (ctrl_c[i+1]),
            .nq_out   (nq_c[i+1]),
            .rem_out  (rem_c[i+1]),
            .den_out  (den_c[i+1])
        );
    end

    dtw_scale #(.TIME_BITS(T), .SCALE_FRAC_BITS(SCALE_FRAC_BITS)) u_scale (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .ctrl_in     (ctrl_c[NC]),
        .quot_in     (nq_c[NC]),
        .cm_per_tick (cm_reg),
        .neg_tol     (tol_reg),
        .res_vld     (r_vld),
        .res_status  (r_status),
        .res_dist    (r_dist)
    );

    assign r_data = {r_dist, r_status};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg    <= 1'b0;
            skid_vld_reg <= 1'b0;
        end else if (!m_vld_reg || m_tready) begin
            m_vld_reg    <= skid_vld_reg || r_vld;
            skid_vld_reg <= 1'b0;
        end else if (en && r_vld) begin
            skid_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!m_vld_reg || m_tready) begin
            m_data_reg <= skid_vld_reg ? skid_data_reg : r_data;
        end else if (en && r_vld) begin
            skid_data_reg <= r_data;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {{(24-RW){1'b0}}, m_data_reg};

    a_skid_needs_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_vld_reg |-> m_vld_reg)
        else $error("skid entry held while output register empty");

    a_fail_zero_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && (m_data_reg[dtw_pkg::STAT_W-1:0] != dtw_pkg::ST_OK))
        |-> (m_data_reg[RW-1:dtw_pkg::STAT_W] == '0))
        else $error("nonzero distance with failing status");

    a_skid_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && !m_tready) |=> (skid_vld_reg && $stable(skid_data_reg)))
        else $error("skid entry lost while output stalled");

    a_skid_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        (skid_vld_reg && m_tready) |=> (!skid_vld_reg && m_vld_reg))
        else $error("skid entry not moved to output");

endmodule
